// ===== design/psg_pkg.sv =====
// ----------------------------------------------------------------------------
// psg_pkg
// Shared types and constants of the sound generator bank.
// ----------------------------------------------------------------------------
package psg_pkg;

  localparam int unsigned RegAddrW = 4;

  // configuration register indexes
  localparam logic [2:0] CfgNumChips  = 3'd0;
  localparam logic [2:0] CfgPhaseStep = 3'd1;
  localparam logic [2:0] CfgGain      = 3'd2;
  localparam logic [2:0] CfgEnvMode   = 3'd3;
  localparam logic [2:0] CfgVolDiv    = 3'd4;

  // generator register indexes
  localparam logic [3:0] RegNoisePer = 4'd6;
  localparam logic [3:0] RegEnable   = 4'd7;
  localparam logic [3:0] RegVolA     = 4'd8;
  localparam logic [3:0] RegEnvLo    = 4'd11;
  localparam logic [3:0] RegEnvHi    = 4'd12;
  localparam logic [3:0] RegShape    = 4'd13;

  typedef enum logic [3:0] {
    StIdle,
    StRead,     // issue register reads for one chip
    StLoad,     // capture register bytes
    StEnv,      // envelope update
    StNoise,    // noise update
    StChan,     // one tone channel
    StNext,     // write back chip state, advance chip
    StDiv3,     // scale the mix, dividing by three in envelope mode
    StDivV,     // divide by volume divisor
    StOut
  } state_e;

  // per-chip state word held in the state memory
  typedef struct packed {
    logic [5:0]  noise_phase;
    logic [16:0] noise_shift;
    logic [16:0] env_phase;
    logic [3:0]  env_level;
    logic        env_hold;
    logic [3:0]  env_shape;
  } chip_st_t;

  typedef struct packed {
    logic [12:0] phase;
    logic        pol;
  } tone_st_t;

  typedef struct packed {
    logic [3:0] num_chips;
    logic [3:0] phase_step;
    logic [3:0] gain;
    logic       env_mode;
    logic [4:0] vol_div;
  } cfg_t;

  function automatic logic [3:0] shape_level(input logic [3:0] s);
    shape_level = (s < 4'd4 || (s >= 4'd8 && s < 4'd12)) ? 4'd0 : 4'd15;
  endfunction

endpackage

// ===== design/psg_tone_noise_envelope_mixer_top.sv =====
// ----------------------------------------------------------------------------
// psg_tone_noise_envelope_mixer_top
// Bank of square-tone / noise / envelope generators mixed into one sample.
// ----------------------------------------------------------------------------
// Usage: requests enter on the s_axis group. tuser = kind (0 register write,
// 1 sample tick); tdata = {reg_data, reg_addr, chip}. A register write is
// accepted and then passes through the write-back state (a shape write
// rewrites the chip state and reloads the envelope) before the next request
// can be taken; it gives no result. A tick walks the mixed chips one after
// another, each with 16 fetches from the register file, load, envelope,
// noise, three tone channels and write-back, then the divide by three (in
// envelope mode; otherwise only a scale), the serial divide by the volume
// divisor and the load of the output register, which raises m_axis_tvalid.
// The block takes the next request only once that register is free, so a
// stalled receiver holds the input. After reset the register file reads as
// zero through one valid bit per entry, so no clearing pass is needed;
// configuration registers return to 2, 8, 5, 0, 1.
// ----------------------------------------------------------------------------
module psg_tone_noise_envelope_mixer_top #(
  parameter int unsigned MAX_CHIPS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // chip[2:0], reg_addr[6:3], reg_data[14:7]
  input  logic        s_axis_tuser,   // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // mix_value[15:0], dac_code[31:16]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import psg_pkg::*;

  localparam int unsigned CW = (MAX_CHIPS > 1) ? $clog2(MAX_CHIPS) : 1;

  cfg_t cfg;
  psg_cfg u_cfg (.clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
                 .prdata, .pready, .cfg_o(cfg));

  // memories
  logic [7:0]  regf   [MAX_CHIPS*16];
  chip_st_t    cmem   [MAX_CHIPS];
  tone_st_t    tmem   [MAX_CHIPS*3];
  logic [MAX_CHIPS*16-1:0] rvalid_q;
  logic [MAX_CHIPS-1:0] cvalid_q;
  logic [MAX_CHIPS*3-1:0] tv_q;

  state_e st_q, st_d;
  logic [CW-1:0] chip_q, chip_d;
  logic [3:0]   raddr_q, raddr_d;     // register fetch index
  logic [1:0]   ch_q, ch_d;
  logic [7:0]   rb_q [16];
  logic [7:0]   rd_q;
  logic         rdv_q;
  chip_st_t     cs_q, cs_d, crd_q;
  tone_st_t     trd_q;
  logic         is_wr_q, is_wr_d;
  logic [2:0]   wchip_q;
  logic [3:0]   waddr_q;
  logic [7:0]   wdata_q;
  logic signed [24:0] sum_q, sum_d;
  logic [3:0]   n_eff;
  logic         ovalid_q;
  logic [31:0]  odata_q;
  // serial divider
  logic [4:0]   dcnt_q, dcnt_d;
  logic [24:0]  dq_q, dq_d, dr_q, dr_d;
  logic         dneg_q, dneg_d;
  logic [15:0]  w_q, w_d;

  assign n_eff = (cfg.num_chips > 4'(MAX_CHIPS)) ? 4'(MAX_CHIPS) : cfg.num_chips;
  assign s_axis_tready = (st_q == StIdle) && !ovalid_q;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

  logic acc;
  assign acc = s_axis_tvalid && s_axis_tready;

  // register file and state memory read address
  logic [CW+3:0] rf_addr;
  logic [CW-1:0] st_chip;
  logic [CW+1:0] t_addr, t_raddr;
  assign st_chip = acc ? s_axis_tdata[CW-1:0] : (is_wr_q ? wchip_q[CW-1:0] : chip_q);
  assign rf_addr = {chip_q, raddr_q};
  assign t_addr  = (CW+2)'(chip_q) * (CW+2)'(3) + (CW+2)'(ch_q);
  assign t_raddr = (CW+2)'(chip_d) * (CW+2)'(3) + (CW+2)'(ch_d);

  // current channel values
  logic [11:0] per;
  logic [1:0]  en;
  logic [3:0]  vol;
  logic        vsel;
  always_comb begin
    per  = {rb_q[{1'b0, ch_q, 1'b1}][3:0], rb_q[{1'b0, ch_q, 1'b0}]};
    en   = {rb_q[RegEnable][3'(ch_q) + 3'd3], rb_q[RegEnable][3'(ch_q)]} ^ 2'b11;
    vsel = cfg.env_mode && rb_q[RegVolA + 4'(ch_q)][4];
    vol  = vsel ? cs_q.env_level : rb_q[RegVolA + 4'(ch_q)][3:0];
  end

  // tone channel update
  tone_st_t tcur, tnew;
  logic signed [24:0] contrib;
  logic run, hi;
  logic [12:0] tp;
  always_comb begin
    tcur = tv_q[t_addr] ? trd_q : '0;
    tnew = tcur;
    run = (per != 0) && (en != 0) && (cfg.env_mode || vol != 0);
    hi = !((en[0] && tcur.pol) || (en[1] && !cs_q.noise_shift[0]));
    contrib = '0;
    if (run && vol != 0) begin
      contrib = 25'($signed({1'b0, 8'(cfg.gain * vol)}));
      if (!hi) contrib = -contrib;
    end
    tp = tcur.phase + 13'(cfg.phase_step);
    if (run) begin
      tnew.phase = tp;
      if (tp > {1'b0, per}) begin
        tnew.phase = tp - {1'b0, per};
        tnew.pol = !tcur.pol;
      end
    end
  end

  // envelope and noise update
  chip_st_t cenv, cnoise;
  logic [15:0] eper;
  logic [4:0]  nper;
  logic [16:0] ep;
  logic [5:0]  npn;
  always_comb begin
    eper = {rb_q[RegEnvHi], rb_q[RegEnvLo]};
    nper = rb_q[RegNoisePer][4:0];
    cenv = cs_q;
    ep = cs_q.env_phase + 17'(cfg.phase_step);
    if (cfg.env_mode && !cs_q.env_hold && eper != 0) begin
      cenv.env_phase = ep;
      if (ep >= {1'b0, eper}) begin
        cenv.env_phase = ep - {1'b0, eper};
        if (!cs_q.env_shape[3]) begin
          if (cs_q.env_level == 4'd15) begin
            cenv.env_level = cs_q.env_shape[0] ? 4'd0 : 4'd15;
            if (cs_q.env_shape[1]) cenv.env_hold = 1'b1;
          end else cenv.env_level = cs_q.env_level + 4'd1;
        end else begin
          if (cs_q.env_level == 4'd0) begin
            cenv.env_level = cs_q.env_shape[0] ? 4'd15 : 4'd0;
            if (cs_q.env_shape[1]) cenv.env_hold = 1'b1;
          end else cenv.env_level = cs_q.env_level - 4'd1;
        end
      end
    end
    cnoise = cs_q;
    npn = cs_q.noise_phase + 6'(cfg.phase_step);
    if (nper != 0) begin
      cnoise.noise_phase = npn;
      if (npn > {1'b0, nper}) begin
        cnoise.noise_phase = npn - {1'b0, nper};
        cnoise.noise_shift = {cs_q.noise_shift[0] ^ cs_q.noise_shift[3],
                              cs_q.noise_shift[16:1]};
      end
    end
  end

  chip_st_t cread;
  assign cread = cvalid_q[st_chip] ? crd_q
               : '{noise_shift: 17'd1, default: '0};

  // divide the mix by three through the reciprocal, truncating toward zero
  logic [15:0] d3_mag, d3_quo, w3;
  logic [31:0] d3_prod;
  always_comb begin
    d3_mag  = sum_q[24] ? 16'(-sum_q) : 16'(sum_q);
    d3_prod = 32'(d3_mag) * 32'd43691;
    d3_quo  = 16'(d3_prod >> 17);
    w3      = sum_q[24] ? 16'(16'd0 - (d3_quo << 6)) : 16'(d3_quo << 6);
  end

  // next state and datapath
  always_comb begin
    st_d = st_q; chip_d = chip_q; raddr_d = raddr_q; ch_d = ch_q;
    cs_d = cs_q; is_wr_d = is_wr_q; sum_d = sum_q;
    dcnt_d = dcnt_q; dq_d = dq_q; dr_d = dr_q; dneg_d = dneg_q; w_d = w_q;
    case (st_q)
      StIdle: begin
        if (acc) begin
          is_wr_d = !s_axis_tuser;
          chip_d = '0; raddr_d = '0; ch_d = '0; sum_d = '0;
          if (s_axis_tuser) st_d = (n_eff == 0) ? StDiv3 : StRead;
          else st_d = (32'(s_axis_tdata[2:0]) < MAX_CHIPS) ? StNext : StIdle;
        end
      end
      StRead: begin
        raddr_d = raddr_q + 4'd1;
        if (raddr_q == 4'd15) st_d = StLoad;
      end
      StLoad: begin
        cs_d = cread;
        st_d = StEnv;
      end
      StEnv: begin
        cs_d = cenv;
        st_d = StNoise;
      end
      StNoise: begin
        cs_d = cnoise;
        st_d = StChan;
      end
      StChan: begin
        sum_d = sum_q + contrib;
        if (ch_q == 2'd2) st_d = StNext;
        else ch_d = ch_q + 2'd1;
      end
      StNext: begin
        if (is_wr_q) st_d = StIdle;
        else begin
          ch_d = '0; raddr_d = '0;
          chip_d = chip_q + CW'(1);
          if (4'(chip_q) + 4'd1 >= n_eff) st_d = StDiv3;
          else st_d = StRead;
        end
        dcnt_d = '0;
      end
      StDiv3: begin
        w_d = cfg.env_mode ? w3 : 16'(sum_q <<< 6);
        st_d = StDivV;
        dcnt_d = '0;
      end
      StDivV: begin
        if (dcnt_q == 5'd0) begin
          dneg_d = w_q[15];
          dq_d = 25'(w_q[15] ? 16'(-w_q) : w_q);
          dr_d = '0;
          dcnt_d = 5'd1;
        end else begin
          dr_d = {dr_q[23:0], dq_q[15]};
          dq_d = {dq_q[23:0], 1'b0};
          if ({dr_q[23:0], dq_q[15]} >=
              25'((cfg.vol_div == 0) ? 5'd1 : cfg.vol_div)) begin
            dr_d = {dr_q[23:0], dq_q[15]} -
                   25'((cfg.vol_div == 0) ? 5'd1 : cfg.vol_div);
            dq_d[0] = 1'b1;
          end
          dcnt_d = dcnt_q + 5'd1;
          if (dcnt_q == 5'd16) st_d = StOut;
        end
      end
      StOut: st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  // quotient sign for the DAC code
  logic [15:0] qv;
  assign qv = dneg_q ? 16'(-dq_q[15:0]) : dq_q[15:0];

  // memory ports
  always_ff @(posedge clk_i) begin
    rd_q  <= regf[rf_addr];
    rdv_q <= rvalid_q[rf_addr];
    crd_q <= cmem[st_chip];
    trd_q <= tmem[t_raddr];
    if (acc && !s_axis_tuser && 32'(s_axis_tdata[2:0]) < MAX_CHIPS)
      regf[{s_axis_tdata[CW-1:0], s_axis_tdata[6:3]}] <= s_axis_tdata[14:7];
    if (st_q == StChan) tmem[t_addr] <= tnew;
    if (st_q == StNext) begin
      if (is_wr_q) begin
        if (waddr_q == RegShape)
          cmem[st_chip] <= '{noise_phase: cread.noise_phase,
                             noise_shift: cread.noise_shift,
                             env_phase: '0, env_level: shape_level(wdata_q[3:0]),
                             env_hold: 1'b0, env_shape: wdata_q[3:0]};
      end else cmem[st_chip] <= cs_q;
    end
    if (st_q == StRead || st_q == StLoad) begin
      if (st_q == StLoad || raddr_q != 4'd0)
        rb_q[raddr_q - 4'd1] <= rdv_q ? rd_q : 8'd0;
    end
    if (acc) begin
      wchip_q <= s_axis_tdata[2:0];
      waddr_q <= s_axis_tdata[6:3];
      wdata_q <= s_axis_tdata[14:7];
    end
    if (st_q == StOut) odata_q <= {16'h8000 + qv, w_q};
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; chip_q <= '0; raddr_q <= '0; ch_q <= '0;
      is_wr_q <= 1'b0; ovalid_q <= 1'b0;
      rvalid_q <= '0; cvalid_q <= '0; tv_q <= '0;
      cs_q <= '0; sum_q <= '0; dcnt_q <= '0; dq_q <= '0; dr_q <= '0;
      dneg_q <= 1'b0; w_q <= '0;
    end else begin
      st_q <= st_d; chip_q <= chip_d; raddr_q <= raddr_d; ch_q <= ch_d;
      is_wr_q <= is_wr_d; cs_q <= cs_d; sum_q <= sum_d;
      dcnt_q <= dcnt_d; dq_q <= dq_d; dr_q <= dr_d; dneg_q <= dneg_d; w_q <= w_d;
      if (acc && !s_axis_tuser && 32'(s_axis_tdata[2:0]) < MAX_CHIPS)
        rvalid_q[{s_axis_tdata[CW-1:0], s_axis_tdata[6:3]}] <= 1'b1;
      if (st_q == StChan) tv_q[t_addr] <= 1'b1;
      if (st_q == StNext && (!is_wr_q || waddr_q == RegShape))
        cvalid_q[st_chip] <= 1'b1;
      if (st_q == StOut) ovalid_q <= 1'b1;
      else if (m_axis_tready) ovalid_q <= 1'b0;
    end
  end
endmodule

// ===== design/psg_cfg.sv =====
// ----------------------------------------------------------------------------
// psg_cfg
// APB register block for the mixer configuration.
// ----------------------------------------------------------------------------
module psg_cfg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [4:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  output psg_pkg::cfg_t  cfg_o
);
  import psg_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign cfg_o = cfg_q;

  // decode write
  always_comb begin
    cfg_d = cfg_q;
    if (wr && paddr[1:0] == 2'b00) begin
      case (paddr[4:2])
        CfgNumChips:  cfg_d.num_chips  = pwdata[3:0];
        CfgPhaseStep: cfg_d.phase_step = pwdata[3:0];
        CfgGain:      cfg_d.gain       = pwdata[3:0];
        CfgEnvMode:   cfg_d.env_mode   = pwdata[0];
        CfgVolDiv:    cfg_d.vol_div    = pwdata[4:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    case (paddr[4:2])
      CfgNumChips:  prdata = {28'd0, cfg_q.num_chips};
      CfgPhaseStep: prdata = {28'd0, cfg_q.phase_step};
      CfgGain:      prdata = {28'd0, cfg_q.gain};
      CfgEnvMode:   prdata = {31'd0, cfg_q.env_mode};
      CfgVolDiv:    prdata = {27'd0, cfg_q.vol_div};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{num_chips: 4'd2, phase_step: 4'd8, gain: 4'd5, env_mode: 1'b0,
                 vol_div: 5'd1};
    end else begin
      cfg_q <= cfg_d;
    end
  end
endmodule
